// ----- hdl/pes_pkg.sv -----
// Shared types and codes for the periodic event scheduler.
// Depends on nothing; every other file of the block imports it.
package pes_pkg;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 8;
  localparam int MASK_W = 5;
  localparam int USED_W = 3;
  localparam int STAT_W = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [USED_W-1:0] used_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam cmd_t CMD_TICK     = 2'd0;
  localparam cmd_t CMD_REGISTER = 2'd1;
  localparam cmd_t CMD_SET      = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_BAD_ID    = 2'd3;

  localparam id_t ID_EMPTY = '0;

  typedef struct packed {
    mask_t   due_mask;
    used_t   slot_used;
    status_t status;
  } res_t;

endpackage

// ----- hdl/pes_if.sv -----
// Valid/ready channel interfaces for the scheduler's command and result beats.
// Depends on pes_pkg for the payload types.
interface pes_in_if #(parameter int TIME_BITS = 32);
  import pes_pkg::*;

  logic                 valid;
  logic                 ready;
  cmd_t                 cmd;
  logic [TIME_BITS-1:0] now_time;
  id_t                  event_id;
  logic [TIME_BITS-1:0] period;

  modport source (output valid, cmd, now_time, event_id, period, input ready);
  modport sink   (input valid, cmd, now_time, event_id, period, output ready);
endinterface

interface pes_out_if;
  import pes_pkg::*;

  logic    valid;
  logic    ready;
  mask_t   due_mask;
  used_t   slot_used;
  status_t status;

  modport source (output valid, due_mask, slot_used, status, input ready);
  modport sink   (input valid, due_mask, slot_used, status, output ready);
endinterface

// ----- hdl/pes_slot_table.sv -----
// Slot table: ids, deadlines and intervals, with the per-command lookup logic.
// Depends on pes_pkg; instantiated by periodic_event_scheduler_top.
module pes_slot_table #(
  parameter int SLOTS     = 5,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  pes_pkg::cmd_t        cmd,
  input  logic [TIME_BITS-1:0] now_time,
  input  pes_pkg::id_t         event_id,
  input  logic [TIME_BITS-1:0] period,
  output pes_pkg::res_t        result
);
  import pes_pkg::*;

  localparam int EXT_W = (SLOTS > MASK_W) ? SLOTS : MASK_W;

  id_t                  slot_id_r       [SLOTS];
  logic [TIME_BITS-1:0] slot_deadline_r [SLOTS];
  logic [TIME_BITS-1:0] slot_period_r   [SLOTS];

  logic [SLOTS-1:0]     occ;
  logic [SLOTS-1:0]     due;
  logic [SLOTS-1:0]     fire;
  logic [SLOTS-1:0]     wr_hot;
  logic [EXT_W-1:0]     fire_ext;
  logic [TIME_BITS-1:0] diff [SLOTS];

  // Occupancy and due flags for every slot in parallel.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      occ[i]  = (slot_id_r[i] != ID_EMPTY);
      diff[i] = slot_deadline_r[i] - now_time;
      due[i]  = occ[i] && ((diff[i] == '0) || diff[i][TIME_BITS-1]);
    end
  end

  // Slots fill in index order and are never freed, so the first empty slot
  // and the first matching id are plain priority picks.
  always_comb begin
    logic found;
    found    = 1'b0;
    fire     = '0;
    wr_hot   = '0;
    result   = '0;
    case (cmd)
      CMD_TICK: begin
        fire = due;
      end
      CMD_REGISTER: begin
        if (event_id == ID_EMPTY) begin
          result.status = ST_BAD_ID;
        end else begin
          result.status = ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !occ[i]) begin
              found            = 1'b1;
              wr_hot[i]        = 1'b1;
              result.slot_used = USED_W'(i);
              result.status    = ST_OK;
            end
          end
        end
      end
      CMD_SET: begin
        if (event_id == ID_EMPTY) begin
          result.status = ST_BAD_ID;
        end else begin
          result.status = ST_NOT_FOUND;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && (slot_id_r[i] == event_id)) begin
              found            = 1'b1;
              wr_hot[i]        = 1'b1;
              result.slot_used = USED_W'(i);
              result.status    = ST_OK;
            end
          end
        end
      end
      default: begin
        result = '0;
      end
    endcase
    fire_ext        = EXT_W'(fire);
    result.due_mask = fire_ext[MASK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_id_r[i] <= ID_EMPTY;
      end
    end else if (go) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (wr_hot[i]) begin
          slot_id_r[i] <= event_id;
        end
      end
    end
  end

  // Deadlines and intervals are only read for occupied slots, which were
  // written when they were filled.
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (wr_hot[i]) begin
          slot_deadline_r[i] <= now_time + period;
          slot_period_r[i]   <= period;
        end else if (fire[i]) begin
          slot_deadline_r[i] <= now_time + slot_period_r[i];
        end
      end
    end
  end

`ifndef SYNTHESIS
  // Occupied slots always form an unbroken run from slot zero.
  a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ + 1'b1) & occ) == '0)
    else $error("slot occupancy has a hole");

  // A register or set command writes at most one slot's id, deadline and interval.
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_hot))
    else $error("more than one slot written by one command");
`endif

endmodule

// ----- hdl/periodic_event_scheduler_top.sv -----
// Top level of the periodic event scheduler: input and result registers with
// valid/ready control. Depends on pes_pkg, pes_if and pes_slot_table.
//
//  Channel   Direction  Beat payload                          Handshake
//  in_ch     in         cmd, now_time, event_id, period       valid/ready
//  out_ch    out        due_mask, slot_used, status           valid/ready
//
// One beat is taken every cycle when the result side keeps up; a result beat
// is presented once its command has passed the input register and the result
// register, and a stall on out_ch can hold it in either.
// The lookup and slot update run between the input register and the result
// register, so the next command sees the new table.
// rst_n is synchronous and active low; it empties every slot at once.
// A stalled result holds the result register, which in turn holds the input
// register; in_ch.ready drops only when both registers are full and stuck.
module periodic_event_scheduler_top #(
  parameter int SLOTS     = 5,
  parameter int TIME_BITS = 32
) (
  input logic     clk,
  input logic     rst_n,
  pes_in_if.sink  in_ch,
  pes_out_if.source out_ch
);
  import pes_pkg::*;

  // Input register stage.
  logic                 in_v_r;
  logic                 in_v_nxt;
  cmd_t                 cmd_r;
  logic [TIME_BITS-1:0] now_r;
  id_t                  id_r;
  logic [TIME_BITS-1:0] per_r;

  // Result register stage.
  logic                 out_v_r;
  logic                 out_v_nxt;
  res_t                 res_r;
  res_t                 res_nxt;

  logic                 advance;
  logic                 go;
  logic                 in_fire;

  // The held command moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign advance     = !out_v_r || out_ch.ready;
  assign go          = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_fire) begin
      in_v_nxt = 1'b1;
    end else if (go) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (go) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_ch.cmd;
      now_r <= in_ch.now_time;
      id_r  <= in_ch.event_id;
      per_r <= in_ch.period;
    end
    if (go) begin
      res_r <= res_nxt;
    end
  end

  pes_slot_table #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .cmd      (cmd_r),
    .now_time (now_r),
    .event_id (id_r),
    .period   (per_r),
    .result   (res_nxt)
  );

  assign out_ch.valid     = out_v_r;
  assign out_ch.due_mask  = res_r.due_mask;
  assign out_ch.slot_used = res_r.slot_used;
  assign out_ch.status    = res_r.status;

`ifndef SYNTHESIS
  // A held command is not lost while the result side is stalled.
  a_hold_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> (in_v_r && $stable(cmd_r) && $stable(id_r)))
    else $error("held command dropped during a stall");

  // A refused or failed command never reports a slot.
  a_used_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.status != ST_OK)) |-> (res_r.slot_used == '0))
    else $error("slot reported with a failing status");

  // Only ticks fire slots, and ticks always report ok.
  a_mask_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.due_mask != '0)) |->
      ((res_r.status == ST_OK) && (res_r.slot_used == '0)))
    else $error("due mask set on a non-tick result");

  // Every processed command yields a result beat in the next cycle.
  a_go_result: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_v_r)
    else $error("processed command produced no result");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for periodic_event_scheduler_top: drives command beats,
// predicts every result beat and compares it field by field.
// Depends on pes_pkg, pes_if and the scheduler RTL.
module tb;
  import pes_pkg::*;

  localparam int SLOTS     = 5;
  localparam int TIME_BITS = 32;
  localparam int RAND_BEATS = 1150;

  typedef logic [TIME_BITS-1:0] tstamp_t;

  // One command beat as the sender queues it, with the idle cycles that
  // precede it on the channel.
  typedef struct packed {
    cmd_t    cmd;
    tstamp_t now_time;
    id_t     event_id;
    tstamp_t period;
    logic [3:0] gap;
  } cmd_beat_t;

  // How often a side of the channel idles during a stretch of the run.
  typedef enum int unsigned {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

  localparam cmd_t CMD_IGNORED = 2'd3;

  logic clk;
  logic rst_n;

  pes_in_if #(.TIME_BITS(TIME_BITS)) in_ch ();
  pes_out_if out_ch ();

  periodic_event_scheduler_top #(
    .SLOTS    (SLOTS),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the slot table, advanced once per accepted command beat.
  id_t     tbl_id       [SLOTS];
  tstamp_t tbl_deadline [SLOTS];
  tstamp_t tbl_period   [SLOTS];

  cmd_beat_t   pending_beats[$];
  res_t        expected_res[$];
  cmd_beat_t   cur_beat;
  res_t        want_res;
  int unsigned gap_count;
  int unsigned stall_count;
  int unsigned beats_taken;
  int unsigned total_beats;
  int unsigned results_seen;
  int unsigned error_count;
  idle_mode_t  tx_mode;
  idle_mode_t  rx_mode;
  logic        hold_off;
  tstamp_t     now_cursor;
  id_t         known_ids [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input of the block gets a known value before the first edge.
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_TICK;
    in_ch.now_time = '0;
    in_ch.event_id = ID_EMPTY;
    in_ch.period   = '0;
    out_ch.ready   = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic int unsigned draw_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 14);
      default:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  // Applies one command to the shadow table and returns the result beat that
  // the block must produce for it.
  function automatic res_t schedule_step(input cmd_beat_t b);
    res_t    r;
    tstamp_t diff;
    bit      stop;
    r    = '0;
    stop = 1'b0;
    case (b.cmd)
      CMD_TICK: begin
        // Slots fill in order and are never freed, so the scan ends at the
        // first empty slot. A slot is due when deadline minus now, taken as a
        // signed wraparound difference, is zero or negative.
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_id[i] == ID_EMPTY) stop = 1'b1;
          if (!stop) begin
            diff = tbl_deadline[i] - b.now_time;
            if (diff == '0 || diff[TIME_BITS-1]) begin
              r.due_mask[i]   = 1'b1;
              tbl_deadline[i] = b.now_time + tbl_period[i];
            end
          end
        end
      end
      CMD_REGISTER: begin
        if (b.event_id == ID_EMPTY) begin
          r.status = ST_BAD_ID;
        end else begin
          // Duplicate ids are not checked; the first empty slot is taken.
          r.status = ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (!stop && tbl_id[i] == ID_EMPTY) begin
              tbl_id[i]       = b.event_id;
              tbl_deadline[i] = b.now_time + b.period;
              tbl_period[i]   = b.period;
              r.slot_used     = used_t'(i);
              r.status        = ST_OK;
              stop            = 1'b1;
            end
          end
        end
      end
      CMD_SET: begin
        if (b.event_id == ID_EMPTY) begin
          r.status = ST_BAD_ID;
        end else begin
          // Only the first matching slot before any empty one is updated.
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_id[i] == ID_EMPTY) stop = 1'b1;
            if (!stop && tbl_id[i] == b.event_id) begin
              tbl_deadline[i] = b.now_time + b.period;
              tbl_period[i]   = b.period;
              r.slot_used     = used_t'(i);
              r.status        = ST_OK;
              stop            = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic add_beat(input cmd_t cmd, input tstamp_t now_time, input id_t id,
                          input tstamp_t period);
    cmd_beat_t b;
    b.cmd      = cmd;
    b.now_time = now_time;
    b.event_id = id;
    b.period   = period;
    b.gap      = 4'(draw_idle(tx_mode));
    pending_beats.push_back(b);
  endtask

  // Command driver. A beat is accepted at an edge where valid and ready were
  // both high; the prediction is made right then, in acceptance order, so the
  // shadow table sees commands in the same order as the block. A new beat is
  // put on the channel only once the previous one has gone, after its gap.
  always @(posedge clk) begin : cmd_driver
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(schedule_step(cur_beat));
        beats_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_beats.size() != 0 && gap_count >= pending_beats[0].gap) begin
          cur_beat = pending_beats.pop_front();
          in_ch.cmd      <= cur_beat.cmd;
          in_ch.now_time <= cur_beat.now_time;
          in_ch.event_id <= cur_beat.event_id;
          in_ch.period   <= cur_beat.period;
          in_ch.valid    <= 1'b1;
          gap_count = 0;
        end else begin
          in_ch.valid <= 1'b0;
          if (pending_beats.size() != 0) gap_count++;
        end
      end
    end
  end

  // Result monitor and receiver. After each result beat it draws a stall;
  // the stall style changes now and then, and the long hold-off below can
  // keep ready low for a long stretch on top of that.
  always @(posedge clk) begin : result_monitor
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want_res = expected_res.pop_front();
          check_field("due_mask", 32'(out_ch.due_mask), 32'(want_res.due_mask));
          check_field("slot_used", 32'(out_ch.slot_used), 32'(want_res.slot_used));
          check_field("status", 32'(out_ch.status), 32'(want_res.status));
        end
        results_seen++;
        stall_count = draw_idle(rx_mode);
        if ($urandom_range(0, 63) == 0) rx_mode = idle_mode_t'($urandom_range(0, 2));
      end
      if (hold_off || stall_count > 0) begin
        out_ch.ready <= 1'b0;
        if (stall_count > 0) stall_count--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off: both internal registers fill and the block must
  // drop in_ch.ready while the sender keeps offering beats.
  initial begin : long_hold
    hold_off = 1'b0;
    wait (beats_taken >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned pick;
    id_t         id;
    tstamp_t     per;
    cmd_t        cmd;

    rst_n        = 1'b0;
    gap_count    = 0;
    stall_count  = 0;
    beats_taken  = 0;
    results_seen = 0;
    error_count  = 0;
    rx_mode      = IDLE_NONE;
    tx_mode      = IDLE_NONE;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_id[i]       = ID_EMPTY;
      tbl_deadline[i] = '0;
      tbl_period[i]   = '0;
    end
    known_ids[0] = 8'hFF;
    known_ids[1] = 8'h01;
    known_ids[2] = 8'h5A;
    known_ids[3] = 8'hA5;

    // Directed part. The table starts empty: a tick finds nothing and a set
    // finds no id. Id zero is refused by both register and set, and command
    // three is ignored.
    add_beat(CMD_TICK, 32'h0, ID_EMPTY, 32'h0);
    add_beat(CMD_SET, 32'h0, 8'h11, 32'd5);
    add_beat(CMD_REGISTER, 32'h0, ID_EMPTY, 32'd10);
    add_beat(CMD_SET, 32'h0, ID_EMPTY, 32'd10);
    add_beat(CMD_IGNORED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    add_beat(CMD_IGNORED, 32'h0, ID_EMPTY, 32'h0);
    // First slot with a deadline that wraps past zero; ticks before it, on
    // it exactly, and with only part of the table occupied.
    add_beat(CMD_REGISTER, 32'hFFFF_FFF0, 8'hFF, 32'd100);
    add_beat(CMD_TICK, 32'hFFFF_FFF8, ID_EMPTY, 32'h0);
    add_beat(CMD_TICK, 32'h0000_0054, ID_EMPTY, 32'h0);
    // Fill the rest, with a zero interval, the largest interval, a duplicate
    // id, and a deadline exactly half the time range away.
    add_beat(CMD_REGISTER, 32'd5, 8'h01, 32'h0);
    add_beat(CMD_REGISTER, 32'd10, 8'hFF, 32'hFFFF_FFFF);
    add_beat(CMD_REGISTER, 32'h0, 8'h5A, 32'h8000_0000);
    add_beat(CMD_REGISTER, 32'h7FFF_FFFF, 8'hA5, 32'd1000);
    // Table full, then set on a duplicate id (first match) and a missing id.
    add_beat(CMD_REGISTER, 32'd12, 8'h33, 32'd7);
    add_beat(CMD_SET, 32'd20, 8'hFF, 32'd40);
    add_beat(CMD_SET, 32'd20, 8'h77, 32'd40);
    add_beat(CMD_TICK, 32'h0000_0100, ID_EMPTY, 32'h0);
    add_beat(CMD_TICK, 32'h8000_0100, ID_EMPTY, 32'h0);
    add_beat(CMD_SET, 32'h8000_0100, 8'hA5, 32'h0);
    add_beat(CMD_TICK, 32'h8000_0100, ID_EMPTY, 32'h0);
    add_beat(CMD_TICK, 32'hFFFF_FFFF, ID_EMPTY, 32'h0);
    add_beat(CMD_TICK, 32'h0, ID_EMPTY, 32'h0);

    // Random part. Time mostly runs forward in small steps with short
    // intervals, so slots fire often; now and then it jumps anywhere, which
    // exercises the wraparound compare. Ignored commands are not counted.
    now_cursor = 32'hFFFF_FF00;
    n = 0;
    while (n < RAND_BEATS) begin
      if (n % 50 == 0) tx_mode = idle_mode_t'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 32) == 0) now_cursor = $urandom;
        else now_cursor = now_cursor + $urandom_range(0, 24);
        add_beat(CMD_TICK, now_cursor, id_t'($urandom), $urandom);
        n++;
      end else if (pick < 80) begin
        if ($urandom_range(0, 9) == 0) id = id_t'($urandom);
        else id = known_ids[$urandom_range(0, 3)];
        case ($urandom_range(0, 9))
          0:       per = '0;
          1:       per = '1;
          2:       per = $urandom;
          default: per = $urandom_range(1, 60);
        endcase
        add_beat(CMD_SET, now_cursor, id, per);
        n++;
      end else if (pick < 88) begin
        id = ($urandom_range(0, 3) == 0) ? ID_EMPTY : id_t'($urandom);
        add_beat(CMD_REGISTER, now_cursor, id, $urandom);
        n++;
      end else if (pick < 95) begin
        cmd = cmd_t'($urandom_range(0, 2));
        add_beat(cmd, $urandom, id_t'($urandom), $urandom);
        n++;
      end else begin
        add_beat(CMD_IGNORED, $urandom, id_t'($urandom), $urandom);
      end
    end
    total_beats = pending_beats.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_taken < total_beats) @(posedge clk);
    while (expected_res.size() != 0) @(posedge clk);
    // Results follow their commands through the input and result registers; the
    // wait below catches any stray beat.
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
